@@ hdl/lsi_pkg.sv @@
// ----------------------------------------------------------------------------
// Line start index package
// Shared constants, command codes and state encoding for the line start
// index and locator.
// ----------------------------------------------------------------------------
package lsi_pkg;

  // Default sizing of the start table and of text offsets.
  localparam int DEF_MAX_LINES   = 1024;
  localparam int DEF_OFFSET_BITS = 20;

  // Fixed field widths.
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 21;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOCATE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  // Characters that break a line.
  localparam logic [CHAR_W-1:0] CH_LF = 21'd10;
  localparam logic [CHAR_W-1:0] CH_CR = 21'd13;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DONE   = 3'b100
  } lsi_state_t;

endpackage

@@ hdl/lsi_if.sv @@
// ----------------------------------------------------------------------------
// Line start index channels
// Valid/ready channels for command items and locate result items.
// ----------------------------------------------------------------------------

// Command channel: append, locate or restart.
interface lsi_in_if
  import lsi_pkg::*;
#(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
);
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [CHAR_W-1:0]      char_code;
  logic [OFFSET_BITS-1:0] query_offset;

  modport source (output valid, command, char_code, query_offset, input ready);
  modport sink   (input valid, command, char_code, query_offset, output ready);
endinterface

// Result channel: one item per locate command.
interface lsi_out_if
  import lsi_pkg::*;
#(
  parameter int MAX_LINES   = DEF_MAX_LINES,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
);
  localparam int LINE_W = $clog2(MAX_LINES + 1);

  logic                 valid;
  logic                 ready;
  logic [LINE_W-1:0]    line_number;
  logic [OFFSET_BITS:0] column_number;
  logic [LINE_W-1:0]    line_total;
  logic                 table_overflow;

  modport source (output valid, line_number, column_number, line_total,
                  table_overflow, input ready);
  modport sink   (input valid, line_number, column_number, line_total,
                  table_overflow, output ready);
endinterface

@@ hdl/line_start_index_and_locator.sv @@
// ----------------------------------------------------------------------------
// Line start index and locator
// Records the offset of every line start in a character stream and resolves
// offsets to 1-based line and column by a binary search of the table.
// ----------------------------------------------------------------------------
// Append and restart items are accepted back to back. A locate item makes
// one table read per search step, limited by the single memory read port.
// Only one locate is in work at a time; no item is accepted meanwhile.
// Reset (synchronous, rst_n low) leaves one line start at zero; the table
// needs no clearing pass, since only entries below the line count are read.
// ----------------------------------------------------------------------------
module line_start_index_and_locator
  import lsi_pkg::*;
#(
  parameter int MAX_LINES   = DEF_MAX_LINES,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  lsi_in_if.sink      in_ch,
  lsi_out_if.source   out_ch
);

  localparam int IDX_W = $clog2(MAX_LINES);
  localparam int CNT_W = $clog2(MAX_LINES + 1);
  localparam int COL_W = OFFSET_BITS + 1;

  // Text state.
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [OFFSET_BITS-1:0] text_len_r, text_len_nxt;
  logic [OFFSET_BITS-1:0] last_start_r, last_start_nxt;
  logic                   prev_cr_r, prev_cr_nxt;
  logic                   overflow_r, overflow_nxt;

  // Search state.
  lsi_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]       lo_r, lo_nxt;
  logic [IDX_W-1:0]       hi_r, hi_nxt;
  logic [IDX_W-1:0]       mid_r, mid_nxt;
  logic [OFFSET_BITS-1:0] lo_val_r, lo_val_nxt;
  logic [OFFSET_BITS-1:0] clamped_r, clamped_nxt;

  // Result register.
  logic                   out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]       out_line_r, out_line_nxt;
  logic [COL_W-1:0]       out_col_r, out_col_nxt;
  logic [CNT_W-1:0]       out_total_r, out_total_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  // Memory ports.
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [OFFSET_BITS-1:0] wr_data;
  logic [OFFSET_BITS-1:0] rd_data;

  logic                   in_fire;
  logic [OFFSET_BITS-1:0] after;
  logic [IDX_W:0]         span;

  lsi_start_ram #(
    .DEPTH  (MAX_LINES),
    .DATA_W (OFFSET_BITS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (mid_nxt),
    .rd_data (rd_data)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign after       = text_len_r + 1'b1;

  // Next-state logic for appends, restarts and the search.
  always_comb begin
    count_nxt      = count_r;
    text_len_nxt   = text_len_r;
    last_start_nxt = last_start_r;
    prev_cr_nxt    = prev_cr_r;
    overflow_nxt   = overflow_r;
    state_nxt      = state_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    lo_val_nxt     = lo_val_r;
    clamped_nxt    = clamped_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_line_nxt   = out_line_r;
    out_col_nxt    = out_col_r;
    out_total_nxt  = out_total_r;
    out_ovf_nxt    = out_ovf_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[IDX_W-1:0];
    wr_data        = after;
    span           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.command)
            CMD_APPEND: begin
              // A full-length text ignores further characters.
              if (text_len_r != {OFFSET_BITS{1'b1}}) begin
                text_len_nxt = after;
                prev_cr_nxt  = 1'b0;
                if (in_ch.char_code == CH_CR ||
                    (in_ch.char_code == CH_LF && !prev_cr_r)) begin
                  prev_cr_nxt = (in_ch.char_code == CH_CR);
                  // New line start, or a dropped break if the table is full.
                  if (count_r < CNT_W'(MAX_LINES)) begin
                    wr_en          = 1'b1;
                    count_nxt      = count_r + 1'b1;
                    last_start_nxt = after;
                  end else begin
                    overflow_nxt = 1'b1;
                  end
                end else if (in_ch.char_code == CH_LF &&
                             last_start_r == text_len_r) begin
                  // LF after a kept CR moves that start past the LF.
                  wr_en          = 1'b1;
                  wr_addr        = IDX_W'(count_r - 1'b1);
                  last_start_nxt = after;
                end
              end
            end
            CMD_LOCATE: begin
              clamped_nxt = (in_ch.query_offset < text_len_r) ?
                            in_ch.query_offset : text_len_r;
              lo_nxt      = '0;
              lo_val_nxt  = '0;
              hi_nxt      = IDX_W'(count_r - 1'b1);
              span        = {1'b0, hi_nxt} + 1'b1;
              mid_nxt     = IDX_W'(span >> 1);
              state_nxt   = (hi_nxt == '0) ? ST_DONE : ST_SEARCH;
            end
            CMD_RESTART: begin
              count_nxt      = CNT_W'(1);
              text_len_nxt   = '0;
              last_start_nxt = '0;
              prev_cr_nxt    = 1'b0;
              overflow_nxt   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SEARCH: begin
        // Keep the last start not above the clamped offset.
        if (rd_data <= clamped_r) begin
          lo_nxt     = mid_r;
          lo_val_nxt = rd_data;
        end else begin
          hi_nxt = mid_r - 1'b1;
        end
        span    = {1'b0, hi_nxt} - {1'b0, lo_nxt} + 1'b1;
        mid_nxt = lo_nxt + IDX_W'(span >> 1);
        if (lo_nxt >= hi_nxt) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // Load the result once the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_line_nxt  = CNT_W'(lo_r) + 1'b1;
          out_col_nxt   = COL_W'(clamped_r) - COL_W'(lo_val_r) + 1'b1;
          out_total_nxt = count_r;
          out_ovf_nxt   = overflow_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= CNT_W'(1);
      text_len_r   <= '0;
      last_start_r <= '0;
      prev_cr_r    <= 1'b0;
      overflow_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      text_len_r   <= text_len_nxt;
      last_start_r <= last_start_nxt;
      prev_cr_r    <= prev_cr_nxt;
      overflow_r   <= overflow_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Search and result payload registers.
  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    lo_val_r    <= lo_val_nxt;
    clamped_r   <= clamped_nxt;
    out_line_r  <= out_line_nxt;
    out_col_r   <= out_col_nxt;
    out_total_r <= out_total_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.line_number    = out_line_r;
  assign out_ch.column_number  = out_col_r;
  assign out_ch.line_total     = out_total_r;
  assign out_ch.table_overflow = out_ovf_r;

  // The line count stays between one and the table depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(1) && count_r <= CNT_W'(MAX_LINES))
    else $error("line count out of range");

  // Breaks are dropped only with a full table.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |-> count_r == CNT_W'(MAX_LINES))
    else $error("overflow set with room in the table");

  // A search step always has a non-empty interval left.
  a_search_interval: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> lo_r < hi_r)
    else $error("search step with an empty interval");

  // The kept start never lies beyond the clamped offset.
  a_lo_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH || state_r == ST_DONE) |-> lo_val_r <= clamped_r)
    else $error("kept line start beyond query offset");

  // A new result comes only from the finishing state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result item without a finished search");

endmodule

@@ hdl/lsi_start_ram.sv @@
// ----------------------------------------------------------------------------
// Line start table memory
// Single-port-write, single-port-read synchronous memory with registered
// read data.
// ----------------------------------------------------------------------------
module lsi_start_ram
  import lsi_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_LINES,
  parameter int DATA_W = DEF_OFFSET_BITS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
